FILE: rtl/tsme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_pkg
// Shared sizes, opcodes, fault codes, tags and types of the tagged stack
// machine executor.
// ----------------------------------------------------------------------------
package tsme_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int LOCAL_COUNT = 16;
  localparam int CONST_COUNT = 256;

  localparam int FUNC_W  = 1;
  localparam int OPC_W   = 5;
  localparam int ARG_W   = 16;
  localparam int TAG_W   = 3;
  localparam int VAL_W   = 64;
  localparam int PC_W    = 16;
  localparam int FAULT_W = 3;
  localparam int LIMIT_W = 5;

  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int LIM_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int LOC_IDX_W   = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
  localparam int CONST_IDX_W = (CONST_COUNT > 1) ? $clog2(CONST_COUNT) : 1;
  localparam int ENT_W       = TAG_W + VAL_W;

  localparam int REG_COUNT   = 1;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int LIMIT_RESET = 16;
  localparam logic [PADDR_W-3:0] REG_STACK_LIMIT = '0;

  localparam logic [FUNC_W-1:0] FUNC_CONST_WR = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_EXEC     = 1'b1;

  localparam logic [OPC_W-1:0] OP_LDCONST  = 5'd0;
  localparam logic [OPC_W-1:0] OP_LDLOCAL  = 5'd1;
  localparam logic [OPC_W-1:0] OP_STLOCAL  = 5'd2;
  localparam logic [OPC_W-1:0] OP_RET      = 5'd4;
  localparam logic [OPC_W-1:0] OP_CMP      = 5'd5;
  localparam logic [OPC_W-1:0] OP_JMP      = 5'd6;
  localparam logic [OPC_W-1:0] OP_JMPIF    = 5'd7;
  localparam logic [OPC_W-1:0] OP_JMPIFNOT = 5'd8;
  localparam logic [OPC_W-1:0] OP_ADD      = 5'd9;
  localparam logic [OPC_W-1:0] OP_DEFVAR   = 5'd10;

  localparam logic [FAULT_W-1:0] FLT_NONE    = 3'd0;
  localparam logic [FAULT_W-1:0] FLT_OVER    = 3'd1;
  localparam logic [FAULT_W-1:0] FLT_UNDER   = 3'd2;
  localparam logic [FAULT_W-1:0] FLT_ADDTYPE = 3'd3;
  localparam logic [FAULT_W-1:0] FLT_TRUTH   = 3'd4;
  localparam logic [FAULT_W-1:0] FLT_UNIMPL  = 3'd5;

  localparam logic [TAG_W-1:0] TAG_NIL  = 3'd0;
  localparam logic [TAG_W-1:0] TAG_BOOL = 3'd1;
  localparam logic [TAG_W-1:0] TAG_UINT = 3'd2;

  localparam int PC_STEP_LONG  = 3;
  localparam int PC_STEP_SHORT = 1;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] val;
  } ent_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_MERGE
  } stk_op_t;

  typedef struct packed {
    stk_op_t              stk_op;
    ent_t                 push_ent;
    logic                 loc_we;
    logic [LOC_IDX_W-1:0] loc_idx;
    logic [CNT_W-1:0]     cnt_next;
    logic [PC_W-1:0]      pc_next;
    logic                 done;
    ent_t                 res;
    logic [FAULT_W-1:0]   fault;
  } upd_t;

  function automatic logic const_in_range(input logic [ARG_W-1:0] idx);
    logic [ARG_W:0] lim;
    lim = (ARG_W + 1)'(CONST_COUNT);
    return {1'b0, idx} < lim;
  endfunction

  function automatic logic local_in_range(input logic [ARG_W-1:0] idx);
    logic [ARG_W:0] lim;
    lim = (ARG_W + 1)'(LOCAL_COUNT);
    return {1'b0, idx} < lim;
  endfunction

endpackage

FILE: rtl/tsme_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_cmd_if
// Command channel: constant writes and instructions, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsme_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tsme_pkg::FUNC_W-1:0]   func;
  logic [tsme_pkg::OPC_W-1:0]    opcode;
  logic [tsme_pkg::ARG_W-1:0]    operand;
  logic [tsme_pkg::TAG_W-1:0]    entry_type;
  logic [tsme_pkg::VAL_W-1:0]    entry_value;

  modport source (output valid, func, opcode, operand, entry_type, entry_value, input ready);
  modport sink (input valid, func, opcode, operand, entry_type, entry_value, output ready);
endinterface

FILE: rtl/tsme_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_rsp_if
// Response channel: one beat per command, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsme_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tsme_pkg::PC_W-1:0]     next_pc;
  logic                          done_res;
  logic [tsme_pkg::TAG_W-1:0]    result_type;
  logic [tsme_pkg::VAL_W-1:0]    result_value;
  logic [tsme_pkg::FAULT_W-1:0]  fault;

  modport source (output valid, next_pc, done_res, result_type, result_value, fault,
                  input ready);
  modport sink (input valid, next_pc, done_res, result_type, result_value, fault,
                output ready);
endinterface

FILE: rtl/tsme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tsme_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_exec
// Decode and execute one instruction against the current stack top, pc and
// stack count; produce the state update and the response fields.
// ----------------------------------------------------------------------------
module tsme_exec (
  input  logic [tsme_pkg::FUNC_W-1:0]  func,
  input  logic [tsme_pkg::OPC_W-1:0]   opcode,
  input  logic [tsme_pkg::ARG_W-1:0]   operand,
  input  tsme_pkg::ent_t               const_ent,
  input  tsme_pkg::ent_t               local_ent,
  input  tsme_pkg::ent_t               top0,
  input  tsme_pkg::ent_t               top1,
  input  logic [tsme_pkg::CNT_W-1:0]   cnt,
  input  logic [tsme_pkg::LIMIT_W-1:0] stack_limit,
  input  logic [tsme_pkg::PC_W-1:0]    pc,
  output tsme_pkg::upd_t               upd
);

  logic [tsme_pkg::LIM_W-1:0] lim;
  logic [tsme_pkg::LIM_W-1:0] cnt_x;
  logic [tsme_pkg::LIM_W-1:0] cnt_less2;
  logic [tsme_pkg::PC_W-1:0]  pc_long;
  logic [tsme_pkg::PC_W-1:0]  pc_short;
  logic [tsme_pkg::PC_W-1:0]  arg_pc;
  logic                       truth;
  logic                       truth_bad;
  logic                       cmp_eq;
  logic [tsme_pkg::VAL_W-1:0] sum;

  always_comb begin
    if (tsme_pkg::LIM_W'(stack_limit) > tsme_pkg::LIM_W'(tsme_pkg::STACK_DEPTH)) begin
      lim = tsme_pkg::LIM_W'(tsme_pkg::STACK_DEPTH);
    end else begin
      lim = tsme_pkg::LIM_W'(stack_limit);
    end
  end

  assign cnt_x     = tsme_pkg::LIM_W'(cnt);
  assign cnt_less2 = cnt_x - tsme_pkg::LIM_W'(2);
  assign pc_long   = pc + tsme_pkg::PC_W'(tsme_pkg::PC_STEP_LONG);
  assign pc_short  = pc + tsme_pkg::PC_W'(tsme_pkg::PC_STEP_SHORT);
  assign arg_pc    = tsme_pkg::PC_W'(operand);
  assign cmp_eq    = (top0.tag == top1.tag) && (top0.val == top1.val);
  assign sum       = top0.val + top1.val;

  always_comb begin
    truth     = 1'b0;
    truth_bad = 1'b0;
    if (top0.tag == tsme_pkg::TAG_BOOL || top0.tag == tsme_pkg::TAG_UINT) begin
      truth = (top0.val != '0);
    end else if (top0.tag != tsme_pkg::TAG_NIL) begin
      truth_bad = 1'b1;
    end
  end

  always_comb begin
    upd          = '0;
    upd.stk_op   = tsme_pkg::STK_HOLD;
    upd.loc_idx  = operand[tsme_pkg::LOC_IDX_W-1:0];
    upd.cnt_next = cnt;
    upd.pc_next  = pc;
    upd.fault    = tsme_pkg::FLT_NONE;
    if (func == tsme_pkg::FUNC_EXEC) begin
      unique case (opcode)
        tsme_pkg::OP_LDCONST, tsme_pkg::OP_LDLOCAL: begin
          if (cnt_x >= lim) begin
            upd.fault = tsme_pkg::FLT_OVER;
          end else begin
            upd.stk_op = tsme_pkg::STK_PUSH;
            if (opcode == tsme_pkg::OP_LDCONST) begin
              if (tsme_pkg::const_in_range(operand)) begin
                upd.push_ent = const_ent;
              end
            end else if (tsme_pkg::local_in_range(operand)) begin
              upd.push_ent = local_ent;
            end
            upd.cnt_next = cnt + tsme_pkg::CNT_W'(1);
            upd.pc_next  = pc_long;
          end
        end
        tsme_pkg::OP_STLOCAL, tsme_pkg::OP_DEFVAR: begin
          if (cnt == '0) begin
            upd.fault = tsme_pkg::FLT_UNDER;
          end else begin
            upd.stk_op   = tsme_pkg::STK_POP;
            upd.loc_we   = (opcode == tsme_pkg::OP_STLOCAL) && tsme_pkg::local_in_range(operand);
            upd.cnt_next = cnt - tsme_pkg::CNT_W'(1);
            upd.pc_next  = pc_long;
          end
        end
        tsme_pkg::OP_RET: begin
          if (cnt == '0) begin
            upd.fault = tsme_pkg::FLT_UNDER;
          end else begin
            upd.done     = 1'b1;
            upd.res      = top0;
            upd.cnt_next = '0;
            upd.pc_next  = '0;
          end
        end
        tsme_pkg::OP_CMP, tsme_pkg::OP_ADD: begin
          if (cnt_x < tsme_pkg::LIM_W'(2)) begin
            upd.fault = tsme_pkg::FLT_UNDER;
          end else if (opcode == tsme_pkg::OP_ADD &&
                       (top0.tag != tsme_pkg::TAG_UINT || top1.tag != tsme_pkg::TAG_UINT)) begin
            upd.fault = tsme_pkg::FLT_ADDTYPE;
          end else if (cnt_less2 >= lim) begin
            upd.fault = tsme_pkg::FLT_OVER;
          end else begin
            upd.stk_op = tsme_pkg::STK_MERGE;
            if (opcode == tsme_pkg::OP_ADD) begin
              upd.push_ent.tag = tsme_pkg::TAG_UINT;
              upd.push_ent.val = sum;
            end else begin
              upd.push_ent.tag = tsme_pkg::TAG_BOOL;
              upd.push_ent.val = tsme_pkg::VAL_W'(cmp_eq);
            end
            upd.cnt_next = cnt - tsme_pkg::CNT_W'(1);
            upd.pc_next  = pc_short;
          end
        end
        tsme_pkg::OP_JMP: begin
          upd.pc_next = arg_pc;
        end
        tsme_pkg::OP_JMPIF, tsme_pkg::OP_JMPIFNOT: begin
          if (cnt == '0) begin
            upd.fault = tsme_pkg::FLT_UNDER;
          end else if (truth_bad) begin
            upd.fault = tsme_pkg::FLT_TRUTH;
          end else begin
            upd.stk_op   = tsme_pkg::STK_POP;
            upd.cnt_next = cnt - tsme_pkg::CNT_W'(1);
            if (truth ^ (opcode == tsme_pkg::OP_JMPIFNOT)) begin
              upd.pc_next = arg_pc;
            end else begin
              upd.pc_next = pc_long;
            end
          end
        end
        default: begin
          upd.fault = tsme_pkg::FLT_UNIMPL;
        end
      endcase
    end
  end

endmodule

FILE: rtl/tagged_stack_machine_executor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_stack_machine_executor_core
// Bytecode executor on one frame of tagged 64-bit values: operand stack,
// locals, constant table and pc, with an APB register for the stack limit.
// ----------------------------------------------------------------------------
// One command is taken every cycle while the response side does not stall
// and is answered by one response beat (input register, then result
// register). The constant table is a 256-entry RAM read at the acceptance
// edge, so a constant write is visible to the very next command. The
// operand stack is a shift line whose top two entries feed the execute
// logic directly; the whole update of stack, locals and pc is committed as
// the command leaves the input register. No clearing pass follows reset:
// the stack, locals and constant table are undefined until written.
module tagged_stack_machine_executor_core (
  input  logic                          clk,
  input  logic                          rst,
  tsme_cmd_if.sink                      cmd,
  tsme_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsme_pkg::PADDR_W-1:0]  paddr,
  input  logic [tsme_pkg::PDATA_W-1:0]  pwdata,
  output logic [tsme_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic                             s1_valid;
  logic [tsme_pkg::FUNC_W-1:0]      s1_func;
  logic [tsme_pkg::OPC_W-1:0]       s1_opcode;
  logic [tsme_pkg::ARG_W-1:0]       s1_operand;

  logic [tsme_pkg::LIMIT_W-1:0]     stack_limit;
  logic [tsme_pkg::CNT_W-1:0]       cnt;
  logic [tsme_pkg::PC_W-1:0]        pc;
  tsme_pkg::ent_t                   stk [tsme_pkg::STACK_DEPTH];
  tsme_pkg::ent_t                   loc [tsme_pkg::LOCAL_COUNT];

  logic                             cmd_fire;
  logic                             advance;
  logic                             commit;
  logic                             const_we;
  logic [tsme_pkg::ENT_W-1:0]       const_rdata;
  tsme_pkg::ent_t                   const_ent;
  tsme_pkg::ent_t                   local_ent;
  tsme_pkg::upd_t                   upd;

  assign advance   = !rsp.valid || rsp.ready;
  assign cmd.ready = !s1_valid || advance;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign commit    = s1_valid && advance;
  assign const_we  = cmd_fire && (cmd.func == tsme_pkg::FUNC_CONST_WR) &&
                     tsme_pkg::const_in_range(cmd.operand);

  tsme_ram #(
    .WIDTH (tsme_pkg::ENT_W),
    .DEPTH (tsme_pkg::CONST_COUNT)
  ) u_const_ram (
    .clk   (clk),
    .we    (const_we),
    .waddr (cmd.operand[tsme_pkg::CONST_IDX_W-1:0]),
    .wdata ({cmd.entry_type, cmd.entry_value}),
    .re    (cmd_fire),
    .raddr (cmd.operand[tsme_pkg::CONST_IDX_W-1:0]),
    .rdata (const_rdata)
  );

  assign const_ent = tsme_pkg::ent_t'(const_rdata);
  assign local_ent = loc[s1_operand[tsme_pkg::LOC_IDX_W-1:0]];

  tsme_exec u_exec (
    .func        (s1_func),
    .opcode      (s1_opcode),
    .operand     (s1_operand),
    .const_ent   (const_ent),
    .local_ent   (local_ent),
    .top0        (stk[0]),
    .top1        (stk[1]),
    .cnt         (cnt),
    .stack_limit (stack_limit),
    .pc          (pc),
    .upd         (upd)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_fire) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_func    <= cmd.func;
      s1_opcode  <= cmd.opcode;
      s1_operand <= cmd.operand;
    end
  end

  // architectural control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pc  <= '0;
    end else if (commit) begin
      cnt <= upd.cnt_next;
      pc  <= upd.pc_next;
    end
  end

  // operand stack shift line and locals
  always_ff @(posedge clk) begin
    if (commit) begin
      unique case (upd.stk_op)
        tsme_pkg::STK_PUSH: begin
          stk[0] <= upd.push_ent;
          for (int i = 1; i < tsme_pkg::STACK_DEPTH; i++) begin
            stk[i] <= stk[i-1];
          end
        end
        tsme_pkg::STK_POP: begin
          for (int i = 0; i < tsme_pkg::STACK_DEPTH - 1; i++) begin
            stk[i] <= stk[i+1];
          end
        end
        tsme_pkg::STK_MERGE: begin
          stk[0] <= upd.push_ent;
          for (int i = 1; i < tsme_pkg::STACK_DEPTH - 1; i++) begin
            stk[i] <= stk[i+1];
          end
        end
        tsme_pkg::STK_HOLD: begin
        end
        default: begin
        end
      endcase
      if (upd.loc_we) begin
        loc[upd.loc_idx] <= stk[0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.next_pc      <= upd.pc_next;
      rsp.done_res     <= upd.done;
      rsp.result_type  <= upd.res.tag;
      rsp.result_value <= upd.res.val;
      rsp.fault        <= upd.fault;
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_limit <= tsme_pkg::LIMIT_W'(tsme_pkg::LIMIT_RESET);
    end else if (psel && penable && pwrite && pready &&
                 paddr[tsme_pkg::PADDR_W-1:2] == tsme_pkg::REG_STACK_LIMIT) begin
      stack_limit <= pwdata[tsme_pkg::LIMIT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[tsme_pkg::PADDR_W-1:2] == tsme_pkg::REG_STACK_LIMIT) ?
                  tsme_pkg::PDATA_W'(stack_limit) : '0;

endmodule

FILE: sim/tsme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsme_checker
// Watches the command, response and register ports of the stack machine
// executor. It keeps its own copy of the machine state, computes the
// response each accepted command must produce, and compares every response
// beat field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tsme_checker
  import tsme_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  tsme_cmd_if                cmd,
  tsme_rsp_if                rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 mismatches,
  output int                 pending,
  output int                 rets_seen,
  output int                 faults_seen
);

  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               done;
    ent_t               res;
    logic [FAULT_W-1:0] fault;
  } rsp_t;

  ent_t             stk    [STACK_DEPTH];
  ent_t             locs   [LOCAL_COUNT];
  ent_t             consts [CONST_COUNT];
  int               depth;
  logic [PC_W-1:0]  pc;
  logic [LIMIT_W-1:0] limit;
  rsp_t             pending_rsp [$];

  function automatic rsp_t execute_cmd(input logic [FUNC_W-1:0] func,
                                       input logic [OPC_W-1:0] opcode,
                                       input logic [ARG_W-1:0] operand,
                                       input logic [TAG_W-1:0] etype,
                                       input logic [VAL_W-1:0] evalue);
    rsp_t               r;
    int                 lim;
    int                 cnt;
    logic [PC_W-1:0]    npc;
    logic [FAULT_W-1:0] flt;
    ent_t               a;
    ent_t               b;
    ent_t               v;
    logic               truth;
    r = '0;
    lim = (limit > STACK_DEPTH) ? STACK_DEPTH : int'(limit);
    cnt = depth;
    npc = pc;
    flt = FLT_NONE;
    truth = 1'b0;
    v = '0;
    if (func == FUNC_CONST_WR) begin
      if (operand < CONST_COUNT) consts[operand[CONST_IDX_W-1:0]] = {etype, evalue};
    end else begin
      case (opcode)
        OP_LDCONST, OP_LDLOCAL: begin
          if (cnt >= lim) flt = FLT_OVER;
          else begin
            if (opcode == OP_LDCONST && operand < CONST_COUNT)
              v = consts[operand[CONST_IDX_W-1:0]];
            if (opcode == OP_LDLOCAL && operand < LOCAL_COUNT)
              v = locs[operand[LOC_IDX_W-1:0]];
            stk[cnt] = v;
            cnt++;
            npc = pc + PC_W'(PC_STEP_LONG);
          end
        end
        OP_STLOCAL, OP_DEFVAR: begin
          if (cnt < 1) flt = FLT_UNDER;
          else begin
            cnt--;
            if (opcode == OP_STLOCAL && operand < LOCAL_COUNT)
              locs[operand[LOC_IDX_W-1:0]] = stk[cnt];
            npc = pc + PC_W'(PC_STEP_LONG);
          end
        end
        OP_RET: begin
          if (cnt < 1) flt = FLT_UNDER;
          else begin
            r.done = 1'b1;
            r.res = stk[cnt-1];
            cnt = 0;
            npc = '0;
          end
        end
        OP_CMP, OP_ADD: begin
          if (cnt < 2) flt = FLT_UNDER;
          else begin
            a = stk[cnt-1];
            b = stk[cnt-2];
            if (opcode == OP_ADD) begin
              if (a.tag != TAG_UINT || b.tag != TAG_UINT) flt = FLT_ADDTYPE;
              v = {TAG_UINT, a.val + b.val};
            end else begin
              v = {TAG_BOOL, VAL_W'(a == b)};
            end
            if (flt == FLT_NONE && cnt - 2 >= lim) flt = FLT_OVER;
            if (flt == FLT_NONE) begin
              cnt -= 2;
              stk[cnt] = v;
              cnt++;
              npc = pc + PC_W'(PC_STEP_SHORT);
            end
          end
        end
        OP_JMP: npc = operand;
        OP_JMPIF, OP_JMPIFNOT: begin
          if (cnt < 1) flt = FLT_UNDER;
          else begin
            a = stk[cnt-1];
            if (a.tag == TAG_BOOL || a.tag == TAG_UINT) truth = (a.val != '0);
            else if (a.tag != TAG_NIL) flt = FLT_TRUTH;
            if (flt == FLT_NONE) begin
              cnt--;
              if (opcode == OP_JMPIFNOT) truth = !truth;
              npc = truth ? operand : pc + PC_W'(PC_STEP_LONG);
            end
          end
        end
        default: flt = FLT_UNIMPL;
      endcase
      if (flt != FLT_NONE) begin
        cnt = depth;
        npc = pc;
        r.done = 1'b0;
        r.res = '0;
      end
    end
    depth = cnt;
    pc = npc;
    r.next_pc = npc;
    r.fault = flt;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      depth = 0;
      pc = '0;
      limit = LIMIT_W'(LIMIT_RESET);
      pending_rsp.delete();
      mismatches = 0;
      rets_seen = 0;
      faults_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_STACK_LIMIT)
        limit = pwdata[LIMIT_W-1:0];
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: response beat with none expected, actual next_pc %0h fault %0d",
                   $time, rsp.next_pc, rsp.fault);
        end else begin
          want = pending_rsp.pop_front();
          check_field("next_pc", want.next_pc, rsp.next_pc);
          check_field("done_res", want.done, rsp.done_res);
          check_field("result_type", want.res.tag, rsp.result_type);
          check_field("result_value", want.res.val, rsp.result_value);
          check_field("fault", want.fault, rsp.fault);
          if (rsp.done_res) rets_seen++;
          if (rsp.fault != FLT_NONE) faults_seen++;
        end
      end
      if (cmd.valid && cmd.ready)
        pending_rsp.push_back(execute_cmd(cmd.func, cmd.opcode, cmd.operand,
                                          cmd.entry_type, cmd.entry_value));
    end
    pending = pending_rsp.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the tagged stack machine executor. Seeds the
// constant table and locals, runs directed instruction sequences through
// every opcode but JMP and every fault, then random programs and noise
// under several stack limits and handshake gap patterns, including a long
// response hold-off that backs the pipeline up into the command port.
// ----------------------------------------------------------------------------
module tb;
  import tsme_pkg::*;

  localparam logic [OPC_W-1:0] OP_INVOKE  = 5'd3;
  localparam logic [OPC_W-1:0] OP_LDVAR   = 5'd11;
  localparam logic [OPC_W-1:0] OP_HEAP_LO = 5'd12;
  localparam logic [OPC_W-1:0] OP_HEAP_HI = 5'd17;
  localparam logic [OPC_W-1:0] OP_FIRST_BAD = 5'd18;
  localparam logic [OPC_W-1:0] OP_TOP     = 5'd31;
  localparam logic [TAG_W-1:0] TAG_FN  = 3'd3;
  localparam logic [TAG_W-1:0] TAG_STR = 3'd4;
  localparam logic [TAG_W-1:0] TAG_ODD = 3'd7;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL         = 32;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int pending;
  int rets_seen;
  int faults_seen;

  int send_idle;
  int recv_stall;
  bit hold_req;
  bit held;
  int n_sent;
  int n_settings;
  int cycles;
  bit const_ok [CONST_COUNT];
  int const_ids [$];

  tsme_cmd_if cmd_ch ();
  tsme_rsp_if rsp_ch ();

  tagged_stack_machine_executor_core dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tsme_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .pending     (pending),
    .rets_seen   (rets_seen),
    .faults_seen (faults_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
    $display("FAILURE");
    $finish;
  end

  // response side: random stalls, one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return VAL_W'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return TAG_UINT;
    if (r < 70) return TAG_BOOL;
    if (r < 80) return TAG_NIL;
    return TAG_W'($urandom_range(TAG_FN, TAG_ODD));
  endfunction

  // never point at a table entry that has not been written
  function automatic logic [ARG_W-1:0] pick_const();
    if ($urandom_range(0, 9) == 0) return ARG_W'($urandom_range(CONST_COUNT, 65535));
    return ARG_W'(const_ids[$urandom_range(0, const_ids.size() - 1)]);
  endfunction

  task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [OPC_W-1:0] op,
                          input logic [ARG_W-1:0] arg, input logic [TAG_W-1:0] etype,
                          input logic [VAL_W-1:0] evalue);
    while (send_idle != 0 && $urandom_range(0, 99) < send_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= func;
    cmd_ch.opcode      <= op;
    cmd_ch.operand     <= arg;
    cmd_ch.entry_type  <= etype;
    cmd_ch.entry_value <= evalue;
    do @(posedge clk); while (!cmd_ch.ready);
    n_sent++;
  endtask

  task automatic load_const_entry(input logic [ARG_W-1:0] idx, input logic [TAG_W-1:0] tag,
                                  input logic [VAL_W-1:0] val);
    send_cmd(FUNC_CONST_WR, OPC_W'($urandom_range(0, OP_TOP)), idx, tag, val);
    if (idx < CONST_COUNT && !const_ok[idx[CONST_IDX_W-1:0]]) begin
      const_ok[idx[CONST_IDX_W-1:0]] = 1'b1;
      const_ids.push_back(int'(idx));
    end
  endtask

  task automatic issue(input logic [OPC_W-1:0] op, input logic [ARG_W-1:0] arg);
    send_cmd(FUNC_EXEC, op, arg, TAG_W'($urandom_range(0, TAG_ODD)), {$urandom, $urandom});
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input int value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_STACK_LIMIT, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_settings++;
  endtask

  task automatic random_phase(input int n);
    int               stop;
    int               r;
    logic [OPC_W-1:0] op;
    logic [ARG_W-1:0] arg;
    stop = n_sent + n;
    while (n_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        // well-formed program: seed constants, push, operate, maybe return
        repeat ($urandom_range(0, 3))
          load_const_entry(($urandom_range(0, 3) == 0) ? ARG_W'($urandom_range(0, CONST_COUNT-1))
                                                       : ARG_W'($urandom_range(0, POOL-1)),
                           rand_tag(), rand_val());
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 2) == 0)
            issue(OP_LDLOCAL, ($urandom_range(0, 9) == 0) ? ARG_W'($urandom_range(0, 65535))
                                                          : ARG_W'($urandom_range(0, LOCAL_COUNT-1)));
          else
            issue(OP_LDCONST, pick_const());
        end
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 6))
            0: issue(OP_ADD, ARG_W'($urandom_range(0, 65535)));
            1: issue(OP_CMP, ARG_W'($urandom_range(0, 65535)));
            2: issue(OP_STLOCAL, ARG_W'($urandom_range(0, LOCAL_COUNT)));
            3: issue(OP_DEFVAR, ARG_W'($urandom_range(0, 65535)));
            4: issue(OP_JMPIF, ARG_W'($urandom_range(0, 65535)));
            5: issue(OP_JMPIFNOT, ARG_W'($urandom_range(0, 65535)));
            default: issue(OP_JMP, ARG_W'($urandom_range(0, 65535)));
          endcase
        end
        if ($urandom_range(0, 9) < 7) issue(OP_RET, ARG_W'($urandom_range(0, 65535)));
      end else if (r < 88) begin
        op  = OPC_W'($urandom_range(0, OP_TOP));
        arg = ARG_W'($urandom_range(0, 65535));
        if (op == OP_LDCONST) arg = pick_const();
        issue(op, arg);
      end else begin
        load_const_entry(($urandom_range(0, 1) == 0) ? ARG_W'($urandom_range(0, 65535))
                                                     : ARG_W'($urandom_range(0, CONST_COUNT-1)),
                         rand_tag(), rand_val());
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.func        <= FUNC_CONST_WR;
    cmd_ch.opcode      <= OP_LDCONST;
    cmd_ch.operand     <= '0;
    cmd_ch.entry_type  <= TAG_NIL;
    cmd_ch.entry_value <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 1'b0;
    held       = 1'b0;
    n_sent     = 0;
    n_settings = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_limit(LIMIT_RESET);
    load_const_entry(ARG_W'(0), TAG_UINT, '1);
    load_const_entry(ARG_W'(1), TAG_UINT, 64'd1);
    load_const_entry(ARG_W'(2), TAG_BOOL, 64'd1);
    load_const_entry(ARG_W'(3), TAG_NIL, '0);
    load_const_entry(ARG_W'(4), TAG_FN, 64'h8000_0000_0000_0000);
    load_const_entry(ARG_W'(5), TAG_STR, rand_val());
    load_const_entry(ARG_W'(6), TAG_ODD, '0);
    load_const_entry(ARG_W'(CONST_COUNT - 1), TAG_UINT, '0);
    load_const_entry(16'hFFFF, TAG_UINT, 64'd5);
    load_const_entry(ARG_W'(CONST_COUNT), TAG_BOOL, 64'd1);

    // fill every stack slot, overflow once, then pop into every local
    for (int i = 0; i < STACK_DEPTH; i++)
      issue(OP_LDCONST, ARG_W'(const_ids[i % const_ids.size()]));
    issue(OP_LDCONST, '0);
    for (int i = 0; i < LOCAL_COUNT; i++) issue(OP_STLOCAL, ARG_W'(i));

    issue(OP_LDCONST, ARG_W'(0));
    issue(OP_LDCONST, ARG_W'(1));
    issue(OP_ADD, '0);
    issue(OP_LDCONST, ARG_W'(2));
    issue(OP_CMP, '0);
    issue(OP_JMPIF, 16'h1234);
    issue(OP_LDCONST, ARG_W'(4));
    issue(OP_JMPIFNOT, 16'hABCD);
    issue(OP_LDCONST, ARG_W'(1));
    issue(OP_ADD, '0);
    issue(OP_DEFVAR, '0);
    issue(OP_RET, '0);
    issue(OP_RET, '0);
    issue(OP_CMP, '0);
    issue(OP_JMPIF, '0);
    issue(OP_STLOCAL, '0);
    issue(OP_LDCONST, 16'd300);
    issue(OP_STLOCAL, 16'hFFFF);
    issue(OP_LDLOCAL, 16'hFFFF);
    issue(OP_JMPIFNOT, 16'hFFFF);
    issue(OP_LDCONST, ARG_W'(5));
    issue(OP_JMPIF, '0);
    issue(OP_LDCONST, ARG_W'(6));
    issue(OP_JMPIF, '0);
    issue(OP_CMP, '0);
    issue(OP_INVOKE, '0);
    issue(OP_LDVAR, '0);
    issue(OP_HEAP_LO, '0);
    issue(OP_HEAP_HI, '0);
    issue(OP_FIRST_BAD, '0);
    issue(OP_TOP, 16'hFFFF);
    issue(OP_RET, '0);

    random_phase(300);
    set_limit(31);
    send_idle = 78;
    random_phase(250);
    set_limit(1);
    send_idle  = 0;
    recv_stall = 78;
    random_phase(150);
    set_limit(0);
    send_idle  = 9;
    recv_stall = 9;
    random_phase(60);
    set_limit($urandom_range(2, 15));
    random_phase(250);
    set_limit(LIMIT_RESET);
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 1'b1;
    random_phase(250);
    set_limit($urandom_range(1, 31));
    send_idle  = 9;
    recv_stall = 9;
    random_phase(240);
    settle();

    $display("ran %0d commands across %0d stack limit settings and four gap patterns",
             n_sent, n_settings);
    $display("%0d returns and %0d faulting instructions checked, %0d mismatches, %0d left over",
             rets_seen, faults_seen, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
